// ----- rtl/core/packed12_unpack_row_descramble_assert.svh -----
// assertion macros for the packed 12-bit unpack / row descramble block
// no dependencies; included by the top level
`ifndef PACKED12_UNPACK_ROW_DESCRAMBLE_ASSERT_SVH
`define PACKED12_UNPACK_ROW_DESCRAMBLE_ASSERT_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, sampled on clk, off during reset
`define P12U_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication, sampled on clk, off during reset
`define P12U_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define P12U_ASSERT_NOW(lbl, ante, cons)
`define P12U_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- rtl/core/p12u_pkg.sv -----
// shared types and constants for the packed 12-bit unpack / row descramble block
// no dependencies
package p12u_pkg;

  localparam int unsigned MAX_WIDTH  = 2560;
  localparam int unsigned MAX_HEIGHT = 2160;

  localparam int unsigned DIM_W  = 12;
  localparam int unsigned WORD_W = 16;
  localparam int unsigned IDX_W  = 3;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [IDX_W-1:0] REG_PROCESS_EN   = 3'd2;
  localparam logic [IDX_W-1:0] REG_UNPACK_EN    = 3'd3;
  localparam logic [IDX_W-1:0] REG_DESCRAMBLE_EN = 3'd4;

  // position inside a group of three packed words
  typedef enum logic [1:0] {
    PH_WORD0 = 2'd0,
    PH_WORD1 = 2'd1,
    PH_WORD2 = 2'd2
  } phase_t;

  typedef struct packed {
    logic [DIM_W-1:0] frame_width;
    logic [DIM_W-1:0] frame_height;
    logic             process_enable;
    logic             unpack_enable;
    logic             descramble_enable;
  } cfg_t;

  // pixel on offer from the unpack stage
  typedef struct packed {
    logic              valid;
    logic [WORD_W-1:0] pixel;
    logic              last;
    logic              scramble;
  } item_t;

endpackage

// ----- rtl/core/p12u_unpack.sv -----
// input stage: word phase / leftover bits tracking and pixel extraction
// depends on p12u_pkg
module p12u_unpack
  import p12u_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [WORD_W-1:0] in_data_word,
  input  logic              load,
  output item_t             item
);

  phase_t            phase_r, phase_nxt;
  logic [7:0]        carry_r, carry_nxt;
  logic              valid_r;
  logic              sel_r;
  logic              two_r;
  logic              scr_r;
  logic [WORD_W-1:0] pix0_r, pix1_r;

  logic              active, unpack, scramble;
  logic              accept, done;
  logic [WORD_W-1:0] pix0_nxt, pix1_nxt;
  logic              two_nxt;

  assign active = cfg.process_enable &&
                  ({1'b0, cfg.frame_width}  <= (DIM_W+1)'(MAX_WIDTH)) &&
                  ({1'b0, cfg.frame_height} <= (DIM_W+1)'(MAX_HEIGHT));
  assign unpack   = active && cfg.unpack_enable;
  assign scramble = active && cfg.descramble_enable;

  assign done     = load && (sel_r || !two_r);
  assign in_ready = !valid_r || done;
  assign accept   = in_valid && in_ready;

  // next phase; unpacking off restarts the group
  always_comb begin
    phase_nxt = PH_WORD0;
    if (unpack) begin
      unique case (phase_r)
        PH_WORD0: phase_nxt = PH_WORD1;
        PH_WORD1: phase_nxt = PH_WORD2;
        default:  phase_nxt = PH_WORD0;
      endcase
    end
  end

  // pixel extraction and leftover bits for the current phase
  always_comb begin
    carry_nxt = carry_r;
    pix0_nxt  = in_data_word;
    pix1_nxt  = '0;
    two_nxt   = 1'b0;
    if (unpack) begin
      unique case (phase_r)
        PH_WORD0: begin
          pix0_nxt  = {4'h0, in_data_word[15:4]};
          carry_nxt = {4'h0, in_data_word[3:0]};
        end
        PH_WORD1: begin
          pix0_nxt  = {4'h0, carry_r[3:0], in_data_word[15:8]};
          carry_nxt = in_data_word[7:0];
        end
        default: begin
          pix0_nxt  = {4'h0, carry_r, in_data_word[15:12]};
          pix1_nxt  = {4'h0, in_data_word[11:0]};
          two_nxt   = 1'b1;
          carry_nxt = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_WORD0;
      carry_r <= '0;
      valid_r <= 1'b0;
      sel_r   <= 1'b0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      carry_r <= carry_nxt;
      valid_r <= 1'b1;
      sel_r   <= 1'b0;
    end else if (done) begin
      valid_r <= 1'b0;
      sel_r   <= 1'b0;
    end else if (load) begin
      sel_r   <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pix0_r <= pix0_nxt;
      pix1_r <= pix1_nxt;
      two_r  <= two_nxt;
      scr_r  <= scramble;
    end
  end

  assign item.valid    = valid_r;
  assign item.pixel    = sel_r ? pix1_r : pix0_r;
  assign item.last     = !two_r || sel_r;
  assign item.scramble = scr_r;

endmodule

// ----- rtl/core/p12u_place.sv -----
// output stage: source position counters, row descramble and result register
// depends on p12u_pkg
module p12u_place
  import p12u_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  item_t             item,
  output logic              load,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [WORD_W-1:0] out_pixel_value,
  output logic [DIM_W-1:0]  out_dest_row,
  output logic [DIM_W-1:0]  out_dest_col,
  output logic              out_last_of_item,
  output logic              out_frame_done
);

  logic [DIM_W-1:0]  row_r, row_nxt;
  logic [DIM_W-1:0]  col_r, col_nxt;
  logic              valid_r;
  logic [WORD_W-1:0] pixel_r;
  logic [DIM_W-1:0]  drow_r, dcol_r;
  logic              last_r, done_r;

  logic [DIM_W-1:0]  drow;
  logic              col_wrap, row_wrap, frame_done;

  assign load = item.valid && (!valid_r || out_ready);

  always_comb begin
    if (item.scramble && row_r[0]) begin
      drow = cfg.frame_height - DIM_W'(1) - ((row_r - DIM_W'(1)) >> 1);
    end else if (item.scramble) begin
      drow = row_r >> 1;
    end else begin
      drow = row_r;
    end
  end

  assign col_wrap   = ({1'b0, col_r} + (DIM_W+1)'(1)) >= {1'b0, cfg.frame_width};
  assign row_wrap   = ({1'b0, row_r} + (DIM_W+1)'(1)) >= {1'b0, cfg.frame_height};
  assign frame_done = col_wrap && row_wrap;

  always_comb begin
    col_nxt = col_r + DIM_W'(1);
    row_nxt = row_r;
    if (col_wrap) begin
      col_nxt = '0;
      row_nxt = row_wrap ? '0 : row_r + DIM_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r   <= '0;
      col_r   <= '0;
      valid_r <= 1'b0;
    end else if (load) begin
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pixel_r <= item.pixel;
      drow_r  <= drow;
      dcol_r  <= col_r;
      last_r  <= item.last;
      done_r  <= frame_done;
    end
  end

  assign out_valid        = valid_r;
  assign out_pixel_value  = pixel_r;
  assign out_dest_row     = drow_r;
  assign out_dest_col     = dcol_r;
  assign out_last_of_item = last_r;
  assign out_frame_done   = done_r;

endmodule

// ----- rtl/core/packed12_unpack_row_descramble.sv -----
// a request passes the word register, then the result register, before it shows at the output
// throughput: one word per cycle while out_ready is high; the third word of a packed group
// gives two pixels and holds the input while the second pixel is passed on
// the output register emits at most one pixel per cycle
// reset: synchronous active-low; clears word phase, counters, valids and loads config defaults
module packed12_unpack_row_descramble
  import p12u_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // configuration write port
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [DIM_W-1:0]  cfg_wdata,
  // word requests in
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [WORD_W-1:0] in_data_word,
  // pixel requests out
  output logic              out_valid,
  input  logic              out_ready,
  output logic [WORD_W-1:0] out_pixel_value,
  output logic [DIM_W-1:0]  out_dest_row,
  output logic [DIM_W-1:0]  out_dest_col,
  output logic              out_last_of_item,
  output logic              out_frame_done
);

`include "packed12_unpack_row_descramble_assert.svh"

  // configuration registers
  cfg_t  cfg_r;
  item_t item;
  logic  load;

  // register write decode; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_width       <= DIM_W'(MAX_WIDTH);
      cfg_r.frame_height      <= DIM_W'(MAX_HEIGHT);
      cfg_r.process_enable    <= 1'b1;
      cfg_r.unpack_enable     <= 1'b0;
      cfg_r.descramble_enable <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:   cfg_r.frame_width       <= cfg_wdata;
        REG_FRAME_HEIGHT:  cfg_r.frame_height      <= cfg_wdata;
        REG_PROCESS_EN:    cfg_r.process_enable    <= cfg_wdata[0];
        REG_UNPACK_EN:     cfg_r.unpack_enable     <= cfg_wdata[0];
        REG_DESCRAMBLE_EN: cfg_r.descramble_enable <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // word register: tracks the 3-word packing phase and splits words into pixels
  p12u_unpack u_unpack (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_word (in_data_word),
    .load         (load),
    .item         (item)
  );

  // result register: raster counters and odd-row flip to the bottom half
  p12u_place u_place (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .item             (item),
    .load             (load),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pixel_value  (out_pixel_value),
    .out_dest_row     (out_dest_row),
    .out_dest_col     (out_dest_col),
    .out_last_of_item (out_last_of_item),
    .out_frame_done   (out_frame_done)
  );

  // the input only stalls while the word register holds a word not yet fully passed on
  `P12U_ASSERT_NOW(a_stall_has_item, !in_ready, item.valid)
  // an accepted word is always on offer the following cycle
  `P12U_ASSERT_NEXT(a_accept_fills, in_valid && in_ready, item.valid)
  // the first pixel of a split word is followed by its second, flagged last
  `P12U_ASSERT_NEXT(a_split_second, load && !item.last, item.valid && item.last)

endmodule
